/* hdl/assert_macros.svh */
// Assertion macros shared by the quaternion to Euler angle RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check on every clock edge outside reset.
`define QTE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check on every clock edge, reset included.
`define QTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QTE_ASSERT(lbl, clk, rstn, prop, msg)
`define QTE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hdl/qte_pkg.sv */
// Types, constants and the arctangent table of the quaternion to Euler angle block.
// Depends on nothing.
package qte_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int NUM_STAGES    = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int ANG_FRAC      = 16;
    localparam int ANG_LIMIT     = 18000;

    localparam int CW      = 38;   // CORDIC x/y datapath width
    localparam int AW      = 33;   // angle accumulator width
    localparam int NW      = 61;   // isqrt radicand width
    localparam int RW      = 62;   // isqrt working width
    localparam int SQ_STEPS = 31;  // result bits of the square root

    localparam logic signed [AW-1:0] QUARTER_TURN = 33'sd589824000; // 9000 << 16
    localparam logic signed [AW-1:0] ROUND_HALF   = 33'sd32768;
    localparam logic signed [AW-1:0] ACC_LIM      = AW'(ANG_LIMIT);
    localparam logic signed [33:0]   ONE_Q30      = 34'sd1073741824;
    localparam logic [NW-1:0]        ONE_Q60      = 61'h1000_0000_0000_0000;

    localparam logic REG_PITCH_OFFSET = 1'b0;
    localparam logic REG_ROLL_OFFSET  = 1'b1;

    typedef logic signed [15:0] angle_t;
    typedef logic signed [15:0] quat_t;

    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctrl_t;

    typedef struct packed {
        logic signed [31:0] s;
        logic signed [33:0] rn;
        logic signed [33:0] rd;
        logic signed [33:0] yn;
        logic signed [33:0] yd;
    } side_t;

    // atan(2^-i) in hundredths of a degree, scaled by 2^16
    function automatic logic signed [AW-1:0] atan_entry(input int i);
        logic signed [AW-1:0] v;
        case (i)
            0:  v = 33'sd294912000;
            1:  v = 33'sd174096719;
            2:  v = 33'sd91987925;
            3:  v = 33'sd46694507;
            4:  v = 33'sd23437865;
            5:  v = 33'sd11730358;
            6:  v = 33'sd5866610;
            7:  v = 33'sd2933484;
            8:  v = 33'sd1466764;
            9:  v = 33'sd733385;
            10: v = 33'sd366693;
            11: v = 33'sd183346;
            12: v = 33'sd91673;
            13: v = 33'sd45837;
            14: v = 33'sd22918;
            15: v = 33'sd11459;
            16: v = 33'sd5730;
            17: v = 33'sd2865;
            18: v = 33'sd1432;
            19: v = 33'sd716;
            20: v = 33'sd358;
            21: v = 33'sd179;
            22: v = 33'sd90;
            23: v = 33'sd45;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* hdl/qte_front.sv */
// Front end: quaternion products, atan2/asin operands and the radicand 1 - s^2.
// Depends on qte_pkg.
module qte_front
    import qte_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  pipe_ctrl_t ctrl,
    input  quat_t      quat_w,
    input  quat_t      quat_x,
    input  quat_t      quat_y,
    input  quat_t      quat_z,
    output logic       out_valid,
    output logic [NW-1:0] n_out,
    output side_t      side_out
);

    logic [3:0] valid_reg;

    // stage 1: products
    logic signed [31:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [31:0] p_xy_reg, p_wz_reg, p_wy_reg, p_zx_reg;
    // stage 2: operands
    side_t side2_reg, side2_next;
    // stage 3: square
    side_t side3_reg;
    logic [NW-1:0] sq_reg;
    logic signed [63:0] sq_next;
    // stage 4: radicand
    side_t side4_reg;
    logic [NW-1:0] n_reg;

    logic signed [33:0] s_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl.advance) begin
            valid_reg <= {valid_reg[2:0], ctrl.valid};
        end
    end

    always_comb begin
        s_raw = (34'(p_wy_reg) - 34'(p_zx_reg)) <<< 1;
        side2_next.rn = (34'(p_wx_reg) + 34'(p_yz_reg)) <<< 1;
        side2_next.rd = ONE_Q30 - ((34'(p_xx_reg) + 34'(p_yy_reg)) <<< 1);
        side2_next.yn = (34'(p_xy_reg) + 34'(p_wz_reg)) <<< 1;
        side2_next.yd = ONE_Q30 - ((34'(p_yy_reg) + 34'(p_zz_reg)) <<< 1);
        // clamp the asin argument to plus or minus one
        if (s_raw > ONE_Q30) begin
            side2_next.s = 32'(ONE_Q30);
        end else if (s_raw < -ONE_Q30) begin
            side2_next.s = 32'(-ONE_Q30);
        end else begin
            side2_next.s = 32'(s_raw);
        end
        sq_next = side2_reg.s * side2_reg.s;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            p_wx_reg  <= quat_w * quat_x;
            p_yz_reg  <= quat_y * quat_z;
            p_xx_reg  <= quat_x * quat_x;
            p_yy_reg  <= quat_y * quat_y;
            p_zz_reg  <= quat_z * quat_z;
            p_xy_reg  <= quat_x * quat_y;
            p_wz_reg  <= quat_w * quat_z;
            p_wy_reg  <= quat_w * quat_y;
            p_zx_reg  <= quat_z * quat_x;
            side2_reg <= side2_next;
            side3_reg <= side2_reg;
            sq_reg    <= sq_next[NW-1:0];
            side4_reg <= side3_reg;
            n_reg     <= ONE_Q60 - sq_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign n_out     = n_reg;
    assign side_out  = side4_reg;

endmodule

/* hdl/qte_isqrt.sv */
// Pipelined integer square root, one result bit per stage, with sideband carried along.
// Depends on qte_pkg and assert_macros.svh.
`include "assert_macros.svh"
module qte_isqrt
    import qte_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  pipe_ctrl_t    ctrl,
    input  logic [NW-1:0] n_in,
    input  side_t         side_in,
    output logic          out_valid,
    output logic [30:0]   root,
    output side_t         side_out
);

    logic [RW-1:0] rem_src [SQ_STEPS+1];
    logic [RW-1:0] res_src [SQ_STEPS+1];
    side_t         side_src [SQ_STEPS+1];
    logic [RW-1:0] rem_reg [SQ_STEPS];
    logic [RW-1:0] res_reg [SQ_STEPS];
    side_t         side_reg [SQ_STEPS];
    logic [SQ_STEPS-1:0] valid_reg;

    assign rem_src[0]  = RW'(n_in);
    assign res_src[0]  = '0;
    assign side_src[0] = side_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl.advance) begin
            valid_reg <= {valid_reg[SQ_STEPS-2:0], ctrl.valid};
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam logic [RW-1:0] BIT = RW'(1) << (60 - 2 * k);
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_next, res_next;

        always_comb begin
            trial = res_src[k] + BIT;
            if (rem_src[k] >= trial) begin
                rem_next = rem_src[k] - trial;
                res_next = (res_src[k] >> 1) + BIT;
            end else begin
                rem_next = rem_src[k];
                res_next = res_src[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (ctrl.advance) begin
                rem_reg[k]  <= rem_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_src[k];
            end
        end

        assign rem_src[k+1]  = rem_reg[k];
        assign res_src[k+1]  = res_reg[k];
        assign side_src[k+1] = side_reg[k];
    end

    assign out_valid = valid_reg[SQ_STEPS-1];
    assign root      = res_src[SQ_STEPS][30:0];
    assign side_out  = side_src[SQ_STEPS];

    // floor square root leaves a remainder of at most twice the root
    `QTE_ASSERT(a_root_floor, aclk, aresetn, (out_valid |-> (rem_src[SQ_STEPS] <= (res_src[SQ_STEPS] << 1))), "isqrt remainder exceeds 2*root")

endmodule

/* hdl/qte_cordic.sv */
// Pipelined vectoring CORDIC atan2 in hundredths of a degree, rounded and saturated.
// Depends on qte_pkg and assert_macros.svh.
`include "assert_macros.svh"
module qte_cordic
    import qte_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pipe_ctrl_t           ctrl,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] x_in,
    output logic                 out_valid,
    output angle_t               angle
);

    logic signed [CW-1:0] x_src [NUM_STAGES+1];
    logic signed [CW-1:0] y_src [NUM_STAGES+1];
    logic signed [AW-1:0] acc_src [NUM_STAGES+1];
    logic                 zero_src [NUM_STAGES+1];
    logic [NUM_STAGES+1:0] valid_reg;

    logic signed [CW-1:0] pre_x_next, pre_y_next, pre_x_reg, pre_y_reg;
    logic signed [AW-1:0] pre_acc_next, pre_acc_reg;
    logic                 pre_zero_reg;

    logic signed [AW-1:0] rnd, quo;
    angle_t angle_next, angle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl.advance) begin
            valid_reg <= {valid_reg[NUM_STAGES:0], ctrl.valid};
        end
    end

    // fold the left half plane onto the right by a quarter turn
    always_comb begin
        pre_x_next   = x_in;
        pre_y_next   = y_in;
        pre_acc_next = '0;
        if (x_in < 0) begin
            if (y_in >= 0) begin
                pre_x_next   = y_in;
                pre_y_next   = -x_in;
                pre_acc_next = QUARTER_TURN;
            end else begin
                pre_x_next   = -y_in;
                pre_y_next   = x_in;
                pre_acc_next = -QUARTER_TURN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            pre_x_reg    <= pre_x_next;
            pre_y_reg    <= pre_y_next;
            pre_acc_reg  <= pre_acc_next;
            pre_zero_reg <= (x_in == 0) && (y_in == 0);
        end
    end

    assign x_src[0]    = pre_x_reg;
    assign y_src[0]    = pre_y_reg;
    assign acc_src[0]  = pre_acc_reg;
    assign zero_src[0] = pre_zero_reg;

    for (genvar i = 0; i < NUM_STAGES; i++) begin : g_iter
        logic signed [CW-1:0] x_next, y_next, x_reg, y_reg;
        logic signed [AW-1:0] acc_next, acc_reg;
        logic                 zero_reg;

        always_comb begin
            if (y_src[i] > 0) begin
                x_next   = x_src[i] + (y_src[i] >>> i);
                y_next   = y_src[i] - (x_src[i] >>> i);
                acc_next = acc_src[i] + atan_entry(i);
            end else begin
                x_next   = x_src[i] - (y_src[i] >>> i);
                y_next   = y_src[i] + (x_src[i] >>> i);
                acc_next = acc_src[i] - atan_entry(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (ctrl.advance) begin
                x_reg    <= x_next;
                y_reg    <= y_next;
                acc_reg  <= acc_next;
                zero_reg <= zero_src[i];
            end
        end

        assign x_src[i+1]    = x_reg;
        assign y_src[i+1]    = y_reg;
        assign acc_src[i+1]  = acc_reg;
        assign zero_src[i+1] = zero_reg;
    end

    // round half up to whole hundredths, then saturate; an all-zero input vector gives zero
    always_comb begin
        rnd = acc_src[NUM_STAGES] + ROUND_HALF;
        quo = rnd >>> ANG_FRAC;
        if (zero_src[NUM_STAGES]) begin
            angle_next = '0;
        end else if (quo > ACC_LIM) begin
            angle_next = 16'(ACC_LIM);
        end else if (quo < -ACC_LIM) begin
            angle_next = 16'(-ACC_LIM);
        end else begin
            angle_next = 16'(quo);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            angle_reg <= angle_next;
        end
    end

    assign out_valid = valid_reg[NUM_STAGES+1];
    assign angle     = angle_reg;

    `QTE_ASSERT(a_angle_range, aclk, aresetn, (out_valid |-> ((angle <= 16'sd18000) && (angle >= -16'sd18000))), "atan2 angle out of range")

endmodule

/* hdl/quaternion_to_euler_angles.sv */
// Top level: quaternion in, yaw/pitch/roll in hundredths of a degree out.
// Depends on qte_pkg, qte_front, qte_isqrt, qte_cordic and assert_macros.svh.
//
//  channel  direction  handshake            word
//  s_       in         s_valid / s_ready    s_quat_w, s_quat_x, s_quat_y, s_quat_z
//  m_       out        m_valid / m_ready    m_yaw_angle, m_pitch_angle, m_roll_angle
//  cfg_     in         cfg_wr_en            cfg_index, cfg_wr_data
//
// One word enters per cycle unless m_ready stalls the pipeline; the stages are
// four front stages, 31 square root stages (one result bit each), then the
// prerotation, CORDIC_STAGES iterations and the rounding stage of the CORDIC,
// and the output register. Reset is synchronous and clears the valid bits and
// the offsets. A stall at m_ready freezes the whole pipeline together with
// s_ready, so words hold in place and nothing drops or repeats.
`include "assert_macros.svh"
module quaternion_to_euler_angles
    import qte_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  quat_t  s_quat_w,
    input  quat_t  s_quat_x,
    input  quat_t  s_quat_y,
    input  quat_t  s_quat_z,
    output logic   m_valid,
    input  logic   m_ready,
    output angle_t m_yaw_angle,
    output angle_t m_pitch_angle,
    output angle_t m_roll_angle,
    input  logic   cfg_wr_en,
    input  logic   cfg_index,
    input  logic [15:0] cfg_wr_data
);

    logic advance;
    pipe_ctrl_t front_ctrl, sqrt_ctrl, cordic_ctrl;

    logic          front_valid, sqrt_valid;
    logic [NW-1:0] front_n;
    side_t         front_side, sqrt_side;
    logic [30:0]   root;

    logic   yaw_valid, pitch_valid, roll_valid;
    angle_t yaw_ang, pitch_ang, roll_ang;

    angle_t pitch_offset_reg, roll_offset_reg;
    logic   m_valid_reg, m_valid_next;
    angle_t yaw_reg, pitch_reg, pitch_next, roll_reg, roll_next;
    logic signed [16:0] pitch_sum, roll_sum;

    // Advance the whole pipeline whenever the output register is free or drains.
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    assign front_ctrl  = '{advance: advance, valid: s_valid};
    assign sqrt_ctrl   = '{advance: advance, valid: front_valid};
    assign cordic_ctrl = '{advance: advance, valid: sqrt_valid};

    // Offsets: the user must write them only while idle, so no shadowing is needed; the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_offset_reg <= '0;
            roll_offset_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PITCH_OFFSET: pitch_offset_reg <= cfg_wr_data;
                REG_ROLL_OFFSET:  roll_offset_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    qte_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (front_ctrl),
        .quat_w    (s_quat_w),
        .quat_x    (s_quat_x),
        .quat_y    (s_quat_y),
        .quat_z    (s_quat_z),
        .out_valid (front_valid),
        .n_out     (front_n),
        .side_out  (front_side)
    );

    // cos(pitch) = sqrt(1 - s^2); roll and yaw operands ride along as sideband
    qte_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (sqrt_ctrl),
        .n_in      (front_n),
        .side_in   (front_side),
        .out_valid (sqrt_valid),
        .root      (root),
        .side_out  (sqrt_side)
    );

    qte_cordic u_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (cordic_ctrl),
        .y_in      (CW'(sqrt_side.yn)),
        .x_in      (CW'(sqrt_side.yd)),
        .out_valid (yaw_valid),
        .angle     (yaw_ang)
    );

    // asin(s) taken as atan2(s, sqrt(1 - s^2))
    qte_cordic u_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (cordic_ctrl),
        .y_in      (CW'(sqrt_side.s)),
        .x_in      (CW'($signed({1'b0, root}))),
        .out_valid (pitch_valid),
        .angle     (pitch_ang)
    );

    qte_cordic u_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (cordic_ctrl),
        .y_in      (CW'(sqrt_side.rn)),
        .x_in      (CW'(sqrt_side.rd)),
        .out_valid (roll_valid),
        .angle     (roll_ang)
    );

    // Add the pitch and roll offsets and saturate those sums to a half turn.
    always_comb begin
        pitch_sum = 17'(pitch_ang) + 17'(pitch_offset_reg);
        roll_sum  = 17'(roll_ang) + 17'(roll_offset_reg);
        if (pitch_sum > 17'sd18000) begin
            pitch_next = 16'sd18000;
        end else if (pitch_sum < -17'sd18000) begin
            pitch_next = -16'sd18000;
        end else begin
            pitch_next = 16'(pitch_sum);
        end
        if (roll_sum > 17'sd18000) begin
            roll_next = 16'sd18000;
        end else if (roll_sum < -17'sd18000) begin
            roll_next = -16'sd18000;
        end else begin
            roll_next = 16'(roll_sum);
        end
        m_valid_next = yaw_valid && pitch_valid && roll_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            yaw_reg   <= yaw_ang;
            pitch_reg <= pitch_next;
            roll_reg  <= roll_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_yaw_angle   = yaw_reg;
    assign m_pitch_angle = pitch_reg;
    assign m_roll_angle  = roll_reg;

    `QTE_ASSERT_ALWAYS(a_reset_empty, aclk, (!aresetn |=> !m_valid), "output valid after reset")
    `QTE_ASSERT(a_lanes_aligned, aclk, aresetn, ((yaw_valid == pitch_valid) && (yaw_valid == roll_valid)), "CORDIC lanes out of step")
    `QTE_ASSERT(a_pitch_range, aclk, aresetn, (m_valid |-> ((m_pitch_angle <= 16'sd18000) && (m_pitch_angle >= -16'sd18000))), "pitch out of range")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for quaternion_to_euler_angles (yaw/pitch/roll from Q1.15 quaternions).
// Depends on qte_pkg and the RTL top level; a local fixed-point model predicts every result word.
`timescale 1ns / 1ps
module tb_top;
    import qte_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_ITEMS   = 1800;
    localparam longint ONE_Q30_L  = 64'sd1 << 30;
    localparam longint CDEG_LIMIT = 18000;

    // atan(2^-i) in hundredths of a degree, scaled by 2^16
    localparam longint ATAN_CDEG [24] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466764, 733385, 366693, 183346,
        91673, 45837, 22918, 11459, 5730, 2865,
        1432, 716, 358, 179, 90, 45};

    typedef struct packed {
        quat_t w, x, y, z;
    } quat_word_t;

    typedef struct packed {
        angle_t yaw, pitch, roll;
    } euler_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    quat_t       s_quat_w, s_quat_x, s_quat_y, s_quat_z;
    logic        m_valid;
    logic        m_ready;
    angle_t      m_yaw_angle, m_pitch_angle, m_roll_angle;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [15:0] cfg_wr_data;

    quat_word_t  quat_queue[$];
    euler_word_t euler_expected[$];
    angle_t      pitch_off, roll_off;
    int          fail_count = 0;
    int          result_count;
    int          idle_cycles;

    quaternion_to_euler_angles dut (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ---------------- prediction ----------------

    function automatic longint sat_cdeg(input longint v);
        if (v > CDEG_LIMIT) return CDEG_LIMIT;
        if (v < -CDEG_LIMIT) return -CDEG_LIMIT;
        return v;
    endfunction

    // Vectoring CORDIC, result in whole hundredths of a degree.
    function automatic longint atan2_cdeg(input longint yi, input longint xi);
        longint x, y, t, acc, dx, dy;
        x = xi;
        y = yi;
        acc = 0;
        if (x == 0 && y == 0) return 0;
        // Rotate the left half plane by a quarter turn first.
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t;
                acc = 64'sd9000 <<< 16;
            end else begin
                t = x; x = -y; y = t;
                acc = -(64'sd9000 <<< 16);
            end
        end
        for (int i = 0; i < NUM_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; acc += ATAN_CDEG[i];
            end else begin
                x -= dx; y += dy; acc -= ATAN_CDEG[i];
            end
        end
        return sat_cdeg((acc + (64'sd1 <<< 15)) >>> 16);
    endfunction

    function automatic longint unsigned isqrt64(input longint unsigned n_in);
        longint unsigned n, res, bitv;
        n = n_in;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic euler_word_t euler_from_quat(input quat_word_t q);
        longint w, x, y, z, rn, rd, yn, yd, s, c;
        euler_word_t e;
        w = q.w; x = q.x; y = q.y; z = q.z;
        rn = 2 * (w * x + y * z);
        rd = ONE_Q30_L - 2 * (x * x + y * y);
        yn = 2 * (x * y + w * z);
        yd = ONE_Q30_L - 2 * (y * y + z * z);
        s  = 2 * (w * y - z * x);
        // Clamp the asin argument to plus or minus one.
        if (s > ONE_Q30_L) s = ONE_Q30_L;
        if (s < -ONE_Q30_L) s = -ONE_Q30_L;
        c = longint'(isqrt64(longint'(ONE_Q30_L * ONE_Q30_L - s * s)));
        e.roll  = angle_t'(sat_cdeg(atan2_cdeg(rn, rd) + longint'(roll_off)));
        e.pitch = angle_t'(sat_cdeg(atan2_cdeg(s, c) + longint'(pitch_off)));
        e.yaw   = angle_t'(sat_cdeg(atan2_cdeg(yn, yd)));
        return e;
    endfunction

    // ---------------- driver ----------------
    // Send in bursts with random gaps; hold the word while it waits for s_ready.
    int burst_left, gap_left;
    quat_word_t head;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_quat_w   <= '0;
            s_quat_x   <= '0;
            s_quat_y   <= '0;
            s_quat_z   <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            if (s_valid && s_ready)
                euler_expected.push_back(
                    euler_from_quat('{s_quat_w, s_quat_x, s_quat_y, s_quat_z}));
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    s_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (quat_queue.size() > 0) begin
                    head = quat_queue.pop_front();
                    s_valid  <= 1'b1;
                    s_quat_w <= head.w;
                    s_quat_x <= head.x;
                    s_quat_y <= head.y;
                    s_quat_z <= head.z;
                    if (burst_left <= 0) begin
                        burst_left <= $urandom_range(1, 40);
                        // Mostly short gaps, often none at all.
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    // Stall on a pattern that changes mode with the cycle count, plus one long hold-off.
    int     cyc, holdoff_left;
    bit     holdoff_done;
    euler_word_t got, exp_word;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            cyc          <= 0;
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
            result_count <= 0;
        end else begin
            cyc <= cyc + 1;
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                got = '{m_yaw_angle, m_pitch_angle, m_roll_angle};
                if (euler_expected.size() == 0) begin
                    $error("result word with no expectation: yaw %0d pitch %0d roll %0d",
                           got.yaw, got.pitch, got.roll);
                    fail_count++;
                end else begin
                    exp_word = euler_expected.pop_front();
                    if (got.yaw !== exp_word.yaw) begin
                        $error("yaw_angle expected %0d actual %0d", exp_word.yaw, got.yaw);
                        fail_count++;
                    end
                    if (got.pitch !== exp_word.pitch) begin
                        $error("pitch_angle expected %0d actual %0d", exp_word.pitch, got.pitch);
                        fail_count++;
                    end
                    if (got.roll !== exp_word.roll) begin
                        $error("roll_angle expected %0d actual %0d", exp_word.roll, got.roll);
                        fail_count++;
                    end
                end
            end
            if (holdoff_left > 0) begin
                m_ready      <= 1'b0;
                holdoff_left <= holdoff_left - 1;
            end else if (!holdoff_done && result_count == 600) begin
                // Long hold-off while the sender keeps offering: fill the pipe.
                m_ready      <= 1'b0;
                holdoff_left <= 400;
                holdoff_done <= 1'b1;
            end else begin
                case (cyc[9:7])
                    3'd1:    m_ready <= ($urandom_range(0, 1) == 0);
                    3'd2:    m_ready <= ($urandom_range(0, 9) != 0);
                    3'd3:    m_ready <= ($urandom_range(0, 4) == 0);
                    3'd5:    m_ready <= cyc[2];
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic wait_drained();
        while (quat_queue.size() > 0 || s_valid || euler_expected.size() > 0)
            @(posedge aclk);
        // Let the pipeline settle before touching the offsets.
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_offsets(input logic [15:0] pitch_v, input logic [15:0] roll_v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= REG_PITCH_OFFSET;
        cfg_wr_data <= pitch_v;
        pitch_off   <= angle_t'(pitch_v);
        @(posedge aclk);
        cfg_index   <= REG_ROLL_OFFSET;
        cfg_wr_data <= roll_v;
        roll_off    <= angle_t'(roll_v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic quat_word_t random_quat();
        quat_word_t q;
        real a, b, c, d, n;
        if ($urandom_range(0, 9) < 6) begin
            // Near-unit attitude with random content.
            a = real'($urandom_range(0, 20000)) - 10000.0;
            b = real'($urandom_range(0, 20000)) - 10000.0;
            c = real'($urandom_range(0, 20000)) - 10000.0;
            d = real'($urandom_range(0, 20000)) - 10000.0;
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 1.0) n = 1.0;
            q.w = quat_t'($rtoi(a / n * 32767.0));
            q.x = quat_t'($rtoi(b / n * 32767.0));
            q.y = quat_t'($rtoi(c / n * 32767.0));
            q.z = quat_t'($rtoi(d / n * 32767.0));
        end else begin
            q = quat_word_t'({$urandom, $urandom});
        end
        return q;
    endfunction

    task automatic push_random(input int count);
        for (int i = 0; i < count; i++) quat_queue.push_back(random_quat());
    endtask

    initial begin
        pitch_off   = '0;
        roll_off    = '0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_PITCH_OFFSET;
        cfg_wr_data = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: identity, zero, extremes, gimbal lock, negative x axis, non-unit.
        quat_queue.push_back('{16'sd32767, 16'sd0, 16'sd0, 16'sd0});
        quat_queue.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
        quat_queue.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
        quat_queue.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
        quat_queue.push_back('{16'sd23170, 16'sd0, 16'sd23170, 16'sd0});
        quat_queue.push_back('{16'sd23170, 16'sd0, -16'sd23170, 16'sd0});
        quat_queue.push_back('{16'sd32767, 16'sd0, 16'sd32767, 16'sd0});
        quat_queue.push_back('{16'sd0, 16'sd32767, 16'sd0, 16'sd0});
        quat_queue.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd32767});
        quat_queue.push_back('{16'sd0, 16'sd0, 16'sd32767, 16'sd0});
        quat_queue.push_back('{16'sd0, -16'sd32768, 16'sd0, 16'sd0});
        quat_queue.push_back('{16'sd23170, 16'sd23170, 16'sd0, 16'sd0});
        quat_queue.push_back('{16'sd23170, 16'sd0, 16'sd0, -16'sd23170});
        quat_queue.push_back('{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
        quat_queue.push_back('{16'sd1, -16'sd1, 16'sd1, -16'sd1});
        wait_drained();

        // Offsets at the extremes, then out of range, then random, then zero.
        write_offsets(16'd18000, -16'sd18000);
        quat_queue.push_back('{16'sd23170, 16'sd0, 16'sd23170, 16'sd0});
        quat_queue.push_back('{16'sd0, -16'sd32768, 16'sd0, 16'sd0});
        push_random(RANDOM_ITEMS / 4);
        wait_drained();

        write_offsets(-16'sd18000, 16'sd18000);
        quat_queue.push_back('{16'sd23170, 16'sd0, -16'sd23170, 16'sd0});
        push_random(RANDOM_ITEMS / 4);
        wait_drained();

        write_offsets(16'h7fff, 16'h8000);
        push_random(RANDOM_ITEMS / 8);
        wait_drained();

        write_offsets(16'h8000, 16'h7fff);
        push_random(RANDOM_ITEMS / 8);
        wait_drained();

        write_offsets(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        push_random(RANDOM_ITEMS / 8);
        wait_drained();

        write_offsets(16'd0, 16'd0);
        push_random(RANDOM_ITEMS / 8);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && euler_expected.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* quaternion_to_euler_angles.f */
+incdir+hdl
hdl/qte_pkg.sv
hdl/qte_front.sv
hdl/qte_isqrt.sv
hdl/qte_cordic.sv
hdl/quaternion_to_euler_angles.sv
tb/tb_top.sv
